### sv/spl_pkg.sv
// Shared types, constants and helpers for the spectral peak lock block.
package spl_pkg;

  localparam int FFT_POINTS  = 4096;
  localparam int HALF_POINTS = FFT_POINTS / 2;
  localparam int SNAP_STEP   = 8;
  localparam int SAMPLE_W    = 24;
  localparam int BIN_W       = $clog2(HALF_POINTS);
  localparam int SNAP_W      = $clog2(SNAP_STEP);
  localparam int SLOT_W      = BIN_W - SNAP_W;
  localparam int POW_W       = 48;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int SWR_W       = 10;
  localparam int ULR_W       = 8;
  localparam int IGN_W       = 6;
  localparam int OUT_DATA_W  = 128;

  localparam logic [BIN_W-1:0] SNAP_BIN  = BIN_W'(SNAP_STEP);
  localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(HALF_POINTS - 1);
  localparam logic [BIN_W-1:0] CLAMP_BIN = BIN_W'(HALF_POINTS - SNAP_STEP);

  localparam logic [POW_W-1:0] MIN_MAG_RST = POW_W'(1000);
  localparam logic [SWR_W-1:0] SWR_RST     = SWR_W'(358);
  localparam logic [ULR_W-1:0] ULR_RST     = ULR_W'(90);
  localparam logic [IGN_W-1:0] IGN_RST     = IGN_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_MAG    = 2'd0,
    CFG_SWITCH_Q8  = 2'd1,
    CFG_UNLOCK_Q8  = 2'd2,
    CFG_IGNORE_LOW = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_KEEP    = 3'd0,
    EV_ACQUIRE = 3'd1,
    EV_WEAK    = 3'd2,
    EV_UNLOCK  = 3'd3,
    EV_SWITCH  = 3'd4
  } lock_event_t;

  // One bin's power on its way to the peak tracker.
  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] bin;
    logic [POW_W-1:0] power;
  } pw_t;

  // End-of-frame summary from the peak tracker.
  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] best_bin;
    logic [POW_W-1:0] best_power;
  } frame_t;

  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] locked_bin;
    logic [BIN_W-1:0] raw_bin;
    logic [POW_W-1:0] raw_power;
    logic [POW_W-1:0] cand_power;
    lock_event_t      event_code;
  } result_t;

  // Round a bin to the nearest grid multiple, clamped to the range SNAP_BIN..CLAMP_BIN.
  function automatic logic [BIN_W-1:0] snap_bin(input logic [BIN_W-1:0] b);
    logic [BIN_W:0] sum;
    logic [BIN_W:0] rounded;
    sum     = {1'b0, b} + (BIN_W+1)'(SNAP_STEP / 2);
    rounded = {sum[BIN_W:SNAP_W], {SNAP_W{1'b0}}};
    if (b < SNAP_BIN) begin
      return SNAP_BIN;
    end else if (rounded[BIN_W]) begin
      return CLAMP_BIN;
    end else begin
      return rounded[BIN_W-1:0];
    end
  endfunction

endpackage

### sv/spl_power.sv
// Squared magnitude pipeline: magnitude, two squares, sum.
module spl_power import spl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] in_re,
  input  logic signed [SAMPLE_W-1:0] in_im,
  input  logic [BIN_W-1:0]           in_bin,
  output pw_t                        pw
);

  logic                v0_r, v1_r;
  logic [SAMPLE_W-1:0] re_abs_r, im_abs_r;
  logic [BIN_W-1:0]    k0_r, k1_r;
  logic [POW_W-1:0]    sq_re_r, sq_im_r;
  pw_t                 pw_r;
  logic [SAMPLE_W-1:0] re_abs, im_abs;

  // The most negative sample maps to 2^(SAMPLE_W-1), which still fits unsigned.
  assign re_abs = in_re[SAMPLE_W-1] ? (~in_re + 1'b1) : in_re;
  assign im_abs = in_im[SAMPLE_W-1] ? (~in_im + 1'b1) : in_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      pw_r.valid <= 1'b0;
    end else begin
      v0_r       <= in_valid;
      v1_r       <= v0_r;
      pw_r.valid <= v1_r;
    end
    re_abs_r   <= re_abs;
    im_abs_r   <= im_abs;
    k0_r       <= in_bin;
    sq_re_r    <= POW_W'(re_abs_r) * POW_W'(re_abs_r);
    sq_im_r    <= POW_W'(im_abs_r) * POW_W'(im_abs_r);
    k1_r       <= k0_r;
    pw_r.bin   <= k1_r;
    // Bin 0 carries the DC term and counts as no power.
    pw_r.power <= (k1_r == '0) ? '0 : sq_re_r + sq_im_r;
  end

  assign pw = pw_r;

endmodule

### sv/spl_grid_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module spl_grid_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/spl_peak.sv
// Running strict maximum over a frame and grid power write-back.
module spl_peak import spl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pw_t               pw,
  input  logic [IGN_W-1:0]  ignore_low_bins,
  output logic              ram_we,
  output logic [SLOT_W-1:0] ram_waddr,
  output logic [POW_W-1:0]  ram_wdata,
  output frame_t            frame
);

  logic [POW_W-1:0] best_power_r, best_power_nxt;
  logic [BIN_W-1:0] best_bin_r, best_bin_nxt;
  frame_t           frame_r;
  logic             take;
  logic             last;

  assign take = pw.valid && (pw.bin >= BIN_W'(ignore_low_bins)) && (pw.power > best_power_r);
  assign last = pw.valid && (pw.bin == LAST_BIN);

  always_comb begin
    best_power_nxt = take ? pw.power : best_power_r;
    best_bin_nxt   = take ? pw.bin : best_bin_r;
  end

  // Every grid bin is written each frame; the clamp bin owns the top slot.
  assign ram_we    = pw.valid && (pw.bin[SNAP_W-1:0] == '0);
  assign ram_waddr = pw.bin[BIN_W-1:SNAP_W];
  assign ram_wdata = pw.power;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_power_r  <= '0;
      best_bin_r    <= SNAP_BIN;
      frame_r.valid <= 1'b0;
    end else begin
      frame_r.valid <= last;
      if (last) begin
        best_power_r <= '0;
        best_bin_r   <= SNAP_BIN;
      end else begin
        best_power_r <= best_power_nxt;
        best_bin_r   <= best_bin_nxt;
      end
    end
    frame_r.best_bin   <= best_bin_nxt;
    frame_r.best_power <= best_power_nxt;
  end

  assign frame = frame_r;

  // The tracker starts each frame from the default peak.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r.valid |-> (best_power_r == '0 && best_bin_r == SNAP_BIN))
    else $error("peak tracker not restarted after frame end");

endmodule

### sv/spl_lock.sv
// End-of-frame snap, grid power lookup and lock hysteresis.
module spl_lock import spl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  frame_t            frame,
  input  logic [POW_W-1:0]  min_magnitude_sq,
  input  logic [SWR_W-1:0]  switch_ratio_q8,
  input  logic [ULR_W-1:0]  unlock_ratio_q8,
  output logic [SLOT_W-1:0] raddr_cand,
  output logic [SLOT_W-1:0] raddr_held,
  input  logic [POW_W-1:0]  rdata_cand,
  input  logic [POW_W-1:0]  rdata_held,
  output result_t           res
);

  localparam int CU_W = POW_W + ULR_W;
  localparam int LS_W = POW_W + SWR_W;

  logic             held_valid_r;
  logic [BIN_W-1:0] held_bin_r;

  logic             f1_valid_r;
  logic [BIN_W-1:0] f1_cand_r, f1_raw_bin_r;
  logic [POW_W-1:0] f1_raw_pow_r;

  logic             f2_valid_r;
  logic [BIN_W-1:0] f2_cand_r, f2_raw_bin_r;
  logic [POW_W-1:0] f2_raw_pow_r, f2_cpow_r, f2_lpow_r;
  logic [CU_W-1:0]  f2_cu_r;
  logic [LS_W-1:0]  f2_ls_r;

  result_t          res_r;
  logic [BIN_W-1:0] cand;
  logic [POW_W-1:0] lpow;
  lock_event_t      ev;
  logic             take_cand;

  assign cand       = snap_bin(frame.best_bin);
  assign raddr_cand = cand[BIN_W-1:SNAP_W];
  assign raddr_held = held_bin_r[BIN_W-1:SNAP_W];

  // A held bin of zero (no lock yet) reads as zero power.
  assign lpow = (held_bin_r == '0) ? '0 : rdata_held;

  always_comb begin
    ev        = EV_KEEP;
    take_cand = 1'b0;
    if (!held_valid_r || f2_cpow_r < min_magnitude_sq) begin
      ev        = EV_ACQUIRE;
      take_cand = 1'b1;
    end else if (f2_cand_r != held_bin_r) begin
      if (f2_lpow_r < min_magnitude_sq) begin
        ev        = EV_WEAK;
        take_cand = 1'b1;
      end else if ({f2_lpow_r, 8'd0} < f2_cu_r) begin
        ev        = EV_UNLOCK;
        take_cand = 1'b1;
      end else if (f2_ls_r < {{(LS_W-POW_W-8){1'b0}}, f2_cpow_r, 8'd0}) begin
        ev        = EV_SWITCH;
        take_cand = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r   <= 1'b0;
      f2_valid_r   <= 1'b0;
      res_r.valid  <= 1'b0;
      held_valid_r <= 1'b0;
      held_bin_r   <= '0;
    end else begin
      f1_valid_r  <= frame.valid;
      f2_valid_r  <= f1_valid_r;
      res_r.valid <= f2_valid_r;
      if (f2_valid_r && take_cand) begin
        held_bin_r   <= f2_cand_r;
        held_valid_r <= 1'b1;
      end
    end
    f1_cand_r        <= cand;
    f1_raw_bin_r     <= frame.best_bin;
    f1_raw_pow_r     <= frame.best_power;
    f2_cand_r        <= f1_cand_r;
    f2_raw_bin_r     <= f1_raw_bin_r;
    f2_raw_pow_r     <= f1_raw_pow_r;
    f2_cpow_r        <= rdata_cand;
    f2_lpow_r        <= lpow;
    f2_cu_r          <= CU_W'(rdata_cand) * CU_W'(unlock_ratio_q8);
    f2_ls_r          <= LS_W'(lpow) * LS_W'(switch_ratio_q8);
    res_r.locked_bin <= take_cand ? f2_cand_r : held_bin_r;
    res_r.raw_bin    <= f2_raw_bin_r;
    res_r.raw_power  <= f2_raw_pow_r;
    res_r.cand_power <= f2_cpow_r;
    res_r.event_code <= ev;
  end

  assign res = res_r;

  a_acquire_sets_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.event_code == EV_ACQUIRE) |-> held_valid_r)
    else $error("acquire reported without a valid lock");

  a_keep_holds_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.event_code == EV_KEEP) |-> (res_r.locked_bin == held_bin_r))
    else $error("kept lock does not report the held bin");

endmodule

### sv/spectral_peak_lock_hysteresis_core.sv
// Spectral peak tracker with lock hysteresis: top level with ports and config.
//
// The block takes one spectrum bin per clock while in_tready is high, bins 0
// to 2047 of a 4096-point transform in order: the magnitude is a three-stage
// pipeline (magnitude, squares, sum) and the running maximum and grid power
// store take one write per cycle. Grid powers live in a 256 x 48 RAM with two
// registered read ports; every slot is rewritten during each frame before it
// is read, so there is no clearing pass after reset. One result comes out per
// frame once the last bin has passed the power pipeline, the peak tracker and
// the lock stages (snap and RAM read, ratio products, hysteresis decision).
// The input stalls only when the last bin of a frame arrives while the
// previous frame's result has not yet been taken from the output.
// Configuration writes must be done while no frame is in progress.
module spectral_peak_lock_hysteresis_core import spl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // bin_real[23:0], bin_imag[47:24]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // locked_bin[10:0], raw_bin[21:11], raw_peak_power[69:22],
  // candidate_power[117:70], lock_event[120:118], zero fill[127:121]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [POW_W-1:0]      min_mag_r;
  logic [SWR_W-1:0]      switch_q8_r;
  logic [ULR_W-1:0]      unlock_q8_r;
  logic [IGN_W-1:0]      ignore_r;
  logic [BIN_W-1:0]      bin_cnt_r;
  logic                  pending_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  in_xfer, last_xfer, out_xfer;

  pw_t                   pw;
  frame_t                frame;
  result_t               res;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr, raddr_cand, raddr_held;
  logic [POW_W-1:0]      ram_wdata, rdata_cand, rdata_held;

  // Only the last bin of a frame needs a free result slot.
  assign in_tready = !(pending_r && bin_cnt_r == LAST_BIN);
  assign in_xfer   = in_tvalid && in_tready;
  assign last_xfer = in_xfer && bin_cnt_r == LAST_BIN;
  assign out_xfer  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r   <= MIN_MAG_RST;
      switch_q8_r <= SWR_RST;
      unlock_q8_r <= ULR_RST;
      ignore_r    <= IGN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_MAG:    min_mag_r   <= cfg_wdata;
        CFG_SWITCH_Q8:  switch_q8_r <= cfg_wdata[SWR_W-1:0];
        CFG_UNLOCK_Q8:  unlock_q8_r <= cfg_wdata[ULR_W-1:0];
        CFG_IGNORE_LOW: ignore_r    <= cfg_wdata[IGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r   <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        bin_cnt_r <= bin_cnt_r + 1'b1;
      end
      if (last_xfer) begin
        pending_r <= 1'b1;
      end else if (out_xfer) begin
        pending_r <= 1'b0;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res.valid) begin
      out_data_r <= {7'd0, res.event_code, res.cand_power, res.raw_power,
                     res.raw_bin, res.locked_bin};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  spl_power u_power (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .in_re    (in_tdata[SAMPLE_W-1:0]),
    .in_im    (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .in_bin   (bin_cnt_r),
    .pw       (pw)
  );

  spl_peak u_peak (
    .clk             (clk),
    .rst_n           (rst_n),
    .pw              (pw),
    .ignore_low_bins (ignore_r),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .frame           (frame)
  );

  spl_grid_ram #(
    .ADDR_W (SLOT_W),
    .DATA_W (POW_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_cand),
    .raddr_b (raddr_held),
    .rdata_a (rdata_cand),
    .rdata_b (rdata_held)
  );

  spl_lock u_lock (
    .clk              (clk),
    .rst_n            (rst_n),
    .frame            (frame),
    .min_magnitude_sq (min_mag_r),
    .switch_ratio_q8  (switch_q8_r),
    .unlock_ratio_q8  (unlock_q8_r),
    .raddr_cand       (raddr_cand),
    .raddr_held       (raddr_held),
    .rdata_cand       (rdata_cand),
    .rdata_held       (rdata_held),
    .res              (res)
  );

  a_out_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> pending_r)
    else $error("result shown without a frame in flight");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_valid_r)
    else $error("frame result arrived while the output register was full");

endmodule
